// ===== rtl/dpr_pkg.sv =====
// Shared types and constants for the dehaze pixel recovery pipeline.
// No dependencies.
package dpr_pkg;

    localparam int unsigned ChanCount    = 3;
    localparam int unsigned RecoverFloor = 51;    // 0.1 floor of t/255, in units of 1/510
    localparam logic [7:0]  AirlightInit = 8'd255;

    // One hazy pixel plus the airlight it is processed with
    typedef struct packed {
        logic [ChanCount-1:0][7:0] ch;
        logic [7:0]                air;
    } dpr_pix_t;

    // Pixel with its transmission estimate
    typedef struct packed {
        dpr_pix_t   pix;
        logic [7:0] trans;
    } dpr_tpix_t;

endpackage

// ===== rtl/dehaze_pixel_recovery_unit.sv =====
// Top level of the dehaze pixel recovery block: airlight register and the
// transmission and recovery pipelines. Depends on dpr_pkg, dpr_trans, dpr_recover.

// Recovers one hazy pixel per clock, while m_ready is high, under the dark
// channel prior. Each transfer on the s_ channel carries three 8-bit channels
// and the filtered dark value; the m_ channel returns the recovered channels
// and the 8-bit transmission, in order, one result per pixel. The pipeline
// is eleven register stages deep: five for the transmission divider and six
// for the radiance divider, the divide stages retiring two quotient bits
// each. A result is registered through the transmission stages, then the
// radiance stages. Each stage holds its own valid bit and refills
// independently, so bubbles close up while the output waits. The airlight
// register resets to 255 and is written through cfg_wr_en/cfg_wr_data; the
// user must write it only while the pipeline is empty, which the block does
// not enforce. Each pixel picks up the value current when it is accepted.
module dehaze_pixel_recovery_unit import dpr_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_channel_0,
    input  logic [7:0] s_channel_1,
    input  logic [7:0] s_channel_2,
    input  logic [7:0] s_dark_value,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_clear_0,
    output logic [7:0] m_clear_1,
    output logic [7:0] m_clear_2,
    output logic [7:0] m_transmission
);

    logic [7:0] airlight_reg;
    logic [7:0] airlight_next;

    dpr_pix_t  in_pix;
    dpr_tpix_t tpix;
    logic      tpix_valid;
    logic      tpix_ready;
    logic [ChanCount-1:0][7:0] clear;

    always_comb begin
        airlight_next = cfg_wr_en ? cfg_wr_data : airlight_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            airlight_reg <= AirlightInit;
        end else begin
            airlight_reg <= airlight_next;
        end
    end

    assign in_pix.ch  = {s_channel_2, s_channel_1, s_channel_0};
    assign in_pix.air = airlight_reg;

    dpr_trans u_trans (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pix    (in_pix),
        .in_dark   (s_dark_value),
        .out_valid (tpix_valid),
        .out_ready (tpix_ready),
        .out_data  (tpix)
    );

    dpr_recover u_recover (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (tpix_valid),
        .in_ready  (tpix_ready),
        .in_data   (tpix),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_clear (clear),
        .out_trans (m_transmission)
    );

    assign m_clear_0 = clear[0];
    assign m_clear_1 = clear[1];
    assign m_clear_2 = clear[2];

endmodule

// ===== rtl/dpr_trans.sv =====
// Transmission estimate: t = floor(255*(4A-3d)/(4A)), pipelined restoring divider.
// Depends on dpr_pkg.
module dpr_trans import dpr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  dpr_pix_t  in_pix,
    input  logic [7:0] in_dark,
    output logic      out_valid,
    input  logic      out_ready,
    output dpr_tpix_t out_data
);

    // Stage 0 sets up the division, stages 1..4 each retire two quotient bits
    localparam int Stages = 5;

    logic [Stages-1:0] valid_reg;
    logic [Stages-1:0] valid_in;
    logic [Stages:0]   rdy;

    dpr_pix_t    pix_reg [Stages];
    logic [17:0] rem_reg [Stages];
    logic [9:0]  div_reg [Stages];
    logic [7:0]  q_reg   [Stages];

    function automatic logic [18:0] tdiv_step(input logic [17:0] r, input logic [9:0] d,
                                              input int sh);
        logic [17:0] m;
        m = 18'({8'b0, d} << sh);
        if (r >= m) begin
            return {1'b1, r - m};
        end
        return {1'b0, r};
    endfunction

    assign rdy[Stages] = out_ready;
    assign in_ready    = rdy[0];
    assign valid_in    = {valid_reg[Stages-2:0], in_valid};

    for (genvar k = 0; k < Stages; k++) begin : g_ctl
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < Stages; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    // Setup: numerator 255*(4A-3d), or zero when the haze term swamps the airlight.
    // With A zero the divisor is zero, every step subtracts nothing and the
    // quotient comes out all ones, which is the full transmission.
    logic [9:0]  a4;
    logic [9:0]  d3;
    logic [9:0]  diff;
    logic [17:0] num0;

    always_comb begin
        a4   = {in_pix.air, 2'b00};
        d3   = {1'b0, in_dark, 1'b0} + {2'b00, in_dark};
        diff = a4 - d3;
        num0 = (a4 > d3) ? ({diff, 8'b0} - {8'b0, diff}) : '0;
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            pix_reg[0] <= in_pix;
            rem_reg[0] <= num0;
            div_reg[0] <= a4;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k < Stages; k++) begin : g_div
        localparam int Hi = 9 - 2 * k;
        logic [18:0] s_hi;
        logic [18:0] s_lo;

        always_comb begin
            s_hi = tdiv_step(rem_reg[k-1], div_reg[k-1], Hi);
            s_lo = tdiv_step(s_hi[17:0], div_reg[k-1], Hi - 1);
        end

        always_ff @(posedge aclk) begin
            if (rdy[k]) begin
                pix_reg[k] <= pix_reg[k-1];
                div_reg[k] <= div_reg[k-1];
                rem_reg[k] <= s_lo[17:0];
                q_reg[k]   <= {q_reg[k-1][5:0], s_hi[18], s_lo[18]};
            end
        end
    end

    assign out_valid      = valid_reg[Stages-1];
    assign out_data.pix   = pix_reg[Stages-1];
    assign out_data.trans = q_reg[Stages-1];

endmodule

// ===== rtl/dpr_recover.sv =====
// Radiance recovery: clear = min(255, |(I-A)*510 + A*D| / D), D = max(2t, 51).
// Depends on dpr_pkg; takes its pixel and t from dpr_trans.
module dpr_recover import dpr_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  dpr_tpix_t in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output logic [ChanCount-1:0][7:0] out_clear,
    output logic [7:0] out_trans
);

    // Stage 0 numerators, stage 1 magnitude and saturation, stages 2..5 divide
    localparam int Stages = 6;

    logic [Stages-1:0] valid_reg;
    logic [Stages-1:0] valid_in;
    logic [Stages:0]   rdy;

    logic [8:0]  den_reg [Stages];
    logic [7:0]  t_reg   [Stages];
    logic [19:0] n_reg   [ChanCount];
    logic [18:0] rem_reg [1:Stages-1][ChanCount];
    logic [7:0]  q_reg   [1:Stages-1][ChanCount];
    logic        sat_reg [1:Stages-1][ChanCount];

    function automatic logic [19:0] rdiv_step(input logic [18:0] r, input logic [8:0] d,
                                              input int sh);
        logic [18:0] m;
        m = 19'({10'b0, d} << sh);
        if (r >= m) begin
            return {1'b1, r - m};
        end
        return {1'b0, r};
    endfunction

    assign rdy[Stages] = out_ready;
    assign in_ready    = rdy[0];
    assign valid_in    = {valid_reg[Stages-2:0], in_valid};

    for (genvar k = 0; k < Stages; k++) begin : g_ctl
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < Stages; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= valid_in[k];
                end
            end
        end
    end

    logic [8:0]  den0;
    logic [16:0] prod0;

    always_comb begin
        den0  = ({in_data.trans, 1'b0} < 9'(RecoverFloor)) ? 9'(RecoverFloor)
                                                           : {in_data.trans, 1'b0};
        prod0 = {9'b0, in_data.pix.air} * {8'b0, den0};
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            den_reg[0] <= den0;
            t_reg[0]   <= in_data.trans;
        end
        for (int k = 1; k < Stages; k++) begin
            if (rdy[k]) begin
                den_reg[k] <= den_reg[k-1];
                t_reg[k]   <= t_reg[k-1];
            end
        end
    end

    for (genvar c = 0; c < ChanCount; c++) begin : g_ch
        logic [8:0]  dlt;
        logic [19:0] ext;
        logic [19:0] n0;
        logic [19:0] mag;

        // Signed (I-A)*510 as a shift-subtract, then add A*D
        always_comb begin
            dlt = {1'b0, in_data.pix.ch[c]} - {1'b0, in_data.pix.air};
            ext = {{11{dlt[8]}}, dlt};
            n0  = (ext << 9) - (ext << 1) + {3'b0, prod0};
            mag = n_reg[c][19] ? (~n_reg[c] + 20'd1) : n_reg[c];
        end

        always_ff @(posedge aclk) begin
            if (rdy[0]) begin
                n_reg[c] <= n0;
            end
            if (rdy[1]) begin
                rem_reg[1][c] <= mag[18:0];
                q_reg[1][c]   <= '0;
                sat_reg[1][c] <= mag[18:0] >= {2'b00, den_reg[0], 8'b0};
            end
        end

        for (genvar k = 2; k < Stages; k++) begin : g_div
            localparam int Hi = 11 - 2 * k;
            logic [19:0] s_hi;
            logic [19:0] s_lo;

            always_comb begin
                s_hi = rdiv_step(rem_reg[k-1][c], den_reg[k-1], Hi);
                s_lo = rdiv_step(s_hi[18:0], den_reg[k-1], Hi - 1);
            end

            always_ff @(posedge aclk) begin
                if (rdy[k]) begin
                    rem_reg[k][c] <= s_lo[18:0];
                    q_reg[k][c]   <= {q_reg[k-1][c][5:0], s_hi[19], s_lo[19]};
                    sat_reg[k][c] <= sat_reg[k-1][c];
                end
            end
        end

        assign out_clear[c] = sat_reg[Stages-1][c] ? 8'hFF : q_reg[Stages-1][c];
    end

    assign out_valid = valid_reg[Stages-1];
    assign out_trans = t_reg[Stages-1];

endmodule

// ===== sim/dehaze_pixel_recovery_unit_test.sv =====
// Testbench for dehaze_pixel_recovery_unit: directed and random pixels checked against
// a built-in predictor of the transmission and radiance recovery.
// Depends on dpr_pkg and the RTL of dehaze_pixel_recovery_unit.
module dehaze_pixel_recovery_unit_test;
    import dpr_pkg::*;

    localparam int CycleLimit  = 200000;
    localparam int IdlePercent = 8;

    typedef struct packed {
        logic [7:0] clear_0;
        logic [7:0] clear_1;
        logic [7:0] clear_2;
        logic [7:0] transmission;
    } clear_pixel_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_channel_0 = 8'd0;
    logic [7:0] s_channel_1 = 8'd0;
    logic [7:0] s_channel_2 = 8'd0;
    logic [7:0] s_dark_value = 8'd0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [7:0] m_clear_0;
    logic [7:0] m_clear_1;
    logic [7:0] m_clear_2;
    logic [7:0] m_transmission;

    clear_pixel_t expected_pixels[$];
    logic [7:0]   airlight_model = AirlightInit;
    bit           throttle = 1'b1;
    int           mismatches = 0;
    int           results_seen = 0;
    int           cycle_count = 0;

    dehaze_pixel_recovery_unit u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_channel_0    (s_channel_0),
        .s_channel_1    (s_channel_1),
        .s_channel_2    (s_channel_2),
        .s_dark_value   (s_dark_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_clear_0      (m_clear_0),
        .m_clear_1      (m_clear_1),
        .m_clear_2      (m_clear_2),
        .m_transmission (m_transmission)
    );

    always #2 aclk = ~aclk;

    // One channel: |(I - A) * 510 + A * den| / den, saturated at 255
    function automatic logic [7:0] recover_level(input logic [7:0] level, input int air,
                                                 input int den);
        int num;
        int lv;
        lv  = level;
        num = (lv - air) * 510 + air * den;
        if (num < 0)
            num = -num;
        num = num / den;
        return (num > 255) ? 8'd255 : num[7:0];
    endfunction

    function automatic clear_pixel_t predict_clear_pixel(input logic [7:0] c0, input logic [7:0] c1,
                                                         input logic [7:0] c2, input logic [7:0] dark,
                                                         input logic [7:0] air);
        clear_pixel_t res;
        int a;
        int d;
        int diff;
        int t;
        int den;
        a = air;
        d = dark;
        if (a == 0) begin
            t = 255;
        end else begin
            diff = 4 * a - 3 * d;
            t    = (diff <= 0) ? 0 : (255 * diff) / (4 * a);
            if (t > 255)
                t = 255;
        end
        den = 2 * t;
        if (den < int'(RecoverFloor))
            den = int'(RecoverFloor);
        res.clear_0      = recover_level(c0, a, den);
        res.clear_1      = recover_level(c1, a, den);
        res.clear_2      = recover_level(c2, a, den);
        res.transmission = t[7:0];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("result %0d %s: got %0d, expected %0d", results_seen, field, got, want);
        mismatches++;
    endtask

    task automatic send_pixel(input logic [7:0] c0, input logic [7:0] c1,
                              input logic [7:0] c2, input logic [7:0] dark);
        @(negedge aclk);
        while (throttle && $urandom_range(99) < IdlePercent) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_channel_0  <= c0;
        s_channel_1  <= c1;
        s_channel_2  <= c2;
        s_dark_value <= dark;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        expected_pixels = {expected_pixels,
                           predict_clear_pixel(c0, c1, c2, dark, airlight_model)};
    endtask

    // Drop valid and wait for every outstanding result
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_airlight(input logic [7:0] value);
        drain_pipeline();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        airlight_model = value;
    endtask

    task automatic test_reset_airlight();
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0);
        send_pixel(8'd255, 8'd128, 8'd0, 8'd255);
        send_pixel(8'd17, 8'd200, 8'd90, 8'd191);
    endtask

    task automatic test_airlight_zero();
        write_airlight(8'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd1, 8'd128, 8'd254, 8'd77);
    endtask

    // Transmission at or below zero, recovery on the 0.1 floor
    task automatic test_dark_above_airlight();
        write_airlight(8'd100);
        send_pixel(8'd0, 8'd255, 8'd100, 8'd133);
        send_pixel(8'd50, 8'd150, 8'd250, 8'd134);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd200);
    endtask

    // Channels well below the airlight give a negative radiance
    task automatic test_negative_recovery();
        write_airlight(8'd200);
        send_pixel(8'd0, 8'd199, 8'd200, 8'd100);
        send_pixel(8'd0, 8'd10, 8'd255, 8'd150);
        send_pixel(8'd3, 8'd7, 8'd11, 8'd0);
    endtask

    task automatic test_field_extremes();
        write_airlight(8'd1);
        send_pixel(8'd0, 8'd255, 8'd1, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd1, 8'd1);
        send_pixel(8'd170, 8'd85, 8'd170, 8'd85);
        send_pixel(8'd85, 8'd170, 8'd85, 8'd170);
    endtask

    // Dark values spread over the whole range, below and above the airlight
    // and around the point where the transmission reaches zero
    task automatic test_random_pixels(input logic [7:0] air, input int count, input bit idling);
        int a;
        int d;
        write_airlight(air);
        throttle = idling;
        a = air;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: d = $urandom_range(255);
                1: d = $urandom_range(a);
                2: d = (4 * a) / 3 + $urandom_range(6) - 3;
                default: d = $urandom_range(255, a);
            endcase
            if (d < 0)
                d = 0;
            if (d > 255)
                d = 255;
            send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), d[7:0]);
        end
        throttle = 1'b1;
    endtask

    always @(negedge aclk)
        m_ready <= !throttle || ($urandom_range(99) >= IdlePercent);

    always @(posedge aclk) begin : check_results
        clear_pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("transfer with nothing pending, clear_0", m_clear_0, 8'd0);
            end else begin
                want = expected_pixels.pop_front();
                if (m_clear_0 !== want.clear_0)
                    report_mismatch("clear_0", m_clear_0, want.clear_0);
                if (m_clear_1 !== want.clear_1)
                    report_mismatch("clear_1", m_clear_1, want.clear_1);
                if (m_clear_2 !== want.clear_2)
                    report_mismatch("clear_2", m_clear_2, want.clear_2);
                if (m_transmission !== want.transmission)
                    report_mismatch("transmission", m_transmission, want.transmission);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("dehaze_pixel_recovery_unit: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (10)
            @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_airlight();
        test_airlight_zero();
        test_dark_above_airlight();
        test_negative_recovery();
        test_field_extremes();
        test_random_pixels(8'd255, 70, 1'b1);
        test_random_pixels(8'($urandom_range(255)), 80, 1'b1);
        test_random_pixels(8'd1, 60, 1'b1);
        test_random_pixels(8'($urandom_range(255)), 80, 1'b0);
        test_random_pixels(8'd0, 50, 1'b1);
        test_random_pixels(8'($urandom_range(2, 254)), 80, 1'b1);
        test_random_pixels(8'($urandom_range(255)), 80, 1'b1);

        drain_pipeline();
        repeat (24)
            @(posedge aclk);
        if (mismatches == 0) begin
            $display("dehaze_pixel_recovery_unit: match");
        end else begin
            $display("dehaze_pixel_recovery_unit: mismatch");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dpr_pkg.sv
rtl/dpr_trans.sv
rtl/dpr_recover.sv
rtl/dehaze_pixel_recovery_unit.sv
sim/dehaze_pixel_recovery_unit_test.sv
